// ===== rtl/rat_pkg.sv =====
`timescale 1ns / 1ps
// rat_pkg: shared types, widths and codes for the range attribute table.
// Used by rat_cell, rat_chain and range_attribute_table. No dependencies.
`default_nettype none

package rat_pkg;

    localparam int unsigned ADDR_W            = 16;
    localparam int unsigned KIND_W            = 2;
    localparam int unsigned IDX_W             = 4;
    localparam int unsigned STATUS_W          = 2;
    localparam int unsigned COUNT_OUT_W       = 5;
    localparam int unsigned IN_DATA_W         = 40;
    localparam int unsigned OUT_DATA_W        = 40;
    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    // request opcodes (tuser on the slave side)
    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result status codes (tuser on the master side)
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_INSERT = 2'd2
    } t_cell_cmd;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_cmd cmd;
        t_entry    new_ent;
        logic      split;
    } t_cell_ctl;

    // handed from a cell to its right neighbor
    typedef struct packed {
        t_entry ent;
        t_entry prev_ent;
        logic   below;
    } t_link;

    // per-cell compare results against the new range
    typedef struct packed {
        logic match;
        logic covered;
        logic encl;
    } t_cell_flags;

    // reduced chain status seen by the controller
    typedef struct packed {
        logic any_match;
        logic any_inside;
        logic any_encl;
    } t_chain_stat;

endpackage

`default_nettype wire

// ===== rtl/rat_cell.sv =====
`timescale 1ns / 1ps
// rat_cell: one table slot; compares against the new range, shifts left on
// delete, trims or takes new or shifted range on insert. Uses rat_pkg.
`default_nettype none

module rat_cell
    import rat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic        i_valid,
    input  wire t_link       i_left,
    input  wire t_entry      i_right_ent,
    output t_link            o_link,
    output t_cell_flags      o_flags,
    output t_entry           o_ent
);

    t_entry r_ent;
    t_entry n_ent;
    t_entry w_src;
    logic   w_below;
    logic [ADDR_W-1:0] w_s;
    logic [ADDR_W-1:0] w_e;
    logic [ADDR_W-1:0] w_e_inc;

    assign w_s     = i_ctl.new_ent.start_addr;
    assign w_e     = i_ctl.new_ent.end_addr;
    assign w_e_inc = w_e + ADDR_W'(1);
    assign w_below = i_valid && (r_ent.start_addr < w_s);

    assign o_flags.match   = i_valid && (r_ent == i_ctl.new_ent);
    assign o_flags.covered = i_valid && (r_ent.start_addr >= w_s) && (r_ent.end_addr <= w_e);
    assign o_flags.encl    = i_valid && (r_ent.start_addr < w_s) && (r_ent.end_addr > w_e);

    assign o_link.ent      = r_ent;
    assign o_link.prev_ent = i_left.ent;
    assign o_link.below    = w_below;
    assign o_ent           = r_ent;

    // split: the enclosing entry sits two slots to the left
    assign w_src = i_ctl.split ? i_left.prev_ent : i_left.ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.cmd)
            CMD_DELETE: begin
                if (i_valid && !w_below) begin
                    n_ent = i_right_ent;
                end
            end
            CMD_INSERT: begin
                if (w_below) begin
                    if (r_ent.end_addr >= w_s) begin
                        n_ent.end_addr = w_s - ADDR_W'(1);
                    end
                end else if (i_left.below) begin
                    n_ent = i_ctl.new_ent;
                end else begin
                    n_ent.kind       = w_src.kind;
                    n_ent.start_addr = (w_src.start_addr > w_e) ? w_src.start_addr : w_e_inc;
                    n_ent.end_addr   = w_src.end_addr;
                end
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

// ===== rtl/rat_chain.sv =====
`timescale 1ns / 1ps
// rat_chain: row of rat_cell slots with neighbor links, status reduction and
// the read-out select. Depends on rat_pkg and rat_cell.
`default_nettype none

module rat_chain
    import rat_pkg::*;
#(
    parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned CNT_W   = $clog2(ENTRIES + 1)
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output t_chain_stat           o_stat,
    output t_entry                o_rd_ent
);

    // only the first sixteen slots are addressable by a read
    localparam int unsigned RD_SPAN = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);

    t_link       w_link  [ENTRIES];
    t_entry      w_ent   [ENTRIES];
    t_cell_flags w_flags [ENTRIES];
    t_link       w_edge;

    // left of slot 0: everything counts as below, so slot 0 can take the new range
    assign w_edge = '{ent: '0, prev_ent: '0, below: 1'b1};

    for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
        rat_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_valid     (CNT_W'(j) < i_count),
            .i_left      ((j == 0) ? w_edge : w_link[(j == 0) ? 0 : j - 1]),
            .i_right_ent (w_ent[(j == ENTRIES - 1) ? j : j + 1]),
            .o_link      (w_link[j]),
            .o_flags     (w_flags[j]),
            .o_ent       (w_ent[j])
        );
    end

    always_comb begin
        o_stat = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            o_stat.any_match  = o_stat.any_match  | w_flags[j].match;
            o_stat.any_inside = o_stat.any_inside | w_flags[j].covered;
            o_stat.any_encl   = o_stat.any_encl   | w_flags[j].encl;
        end
    end

    always_comb begin
        o_rd_ent = '0;
        for (int j = 0; j < RD_SPAN; j++) begin
            if (i_rd_idx == IDX_W'(j)) begin
                o_rd_ent = w_ent[j];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/range_attribute_table.sv =====
`timescale 1ns / 1ps
// range_attribute_table: sorted table of tagged address ranges, top level.
// Depends on rat_pkg and rat_chain (which holds the rat_cell row).
//
// Usage:
//   Slave stream carries requests. tuser = op (0 assign/toggle, 1 read).
//   tdata = kind, start_addr, end_addr, index (low bit first).
//   Master stream carries one result per request. tuser = status,
//   tdata = entry_count, entry_valid, entry_kind, entry_start, entry_end.
//   An assign equal to an existing entry removes it; any other assign cuts
//   away the overlapped parts of old entries and inserts the new range in
//   address order. Bad ranges and overflow are rejected, table untouched.
//
// States from accept: read or reject ANALYZE, FINISH; assign with no entry
//   swallowed ANALYZE, INSERT, FINISH; exact-match removal ANALYZE, DELETE,
//   FINISH; assign swallowing entries ANALYZE, DELETE, INSERT, FINISH. The
//   row of cells removes one swallowed entry per cycle by shifting left,
//   then trims and opens a gap for the new range in one right shift. One
//   request is in flight at a time; s_axis_tready is high only when idle.
//
// Reset clears the entry count and the FSM; slot contents are left as is
// and only slots below the count are ever used.
// A stalled receiver holds the result in the output register; the block
// can take the next request meanwhile but holds its result until the
// register drains.
`default_nettype none

module range_attribute_table
    import rat_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [1:0] kind, [17:2] start_addr, [33:18] end_addr, [37:34] index, [39:38] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [4:0] entry_count, [5] entry_valid, [7:6] entry_kind,
    // [23:8] entry_start, [39:24] entry_end
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]        m_axis_tuser
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ANALYZE = 5'b00010,
        S_DELETE  = 5'b00100,
        S_INSERT  = 5'b01000,
        S_FINISH  = 5'b10000
    } t_state;

    t_state               r_state,   n_state;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic                 r_op;
    t_entry               r_new;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_split,   n_split;
    logic [STATUS_W-1:0]  r_status,  n_status;
    logic                 r_res_vld, n_res_vld;
    t_entry               r_res_ent, n_res_ent;
    logic                 r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [STATUS_W-1:0]  r_m_user;

    t_cell_ctl   w_ctl;
    t_chain_stat w_stat;
    t_entry      w_rd_ent;
    logic        w_accept;
    logic        w_can_emit;
    logic        w_overflow;
    logic        w_rd_hit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_can_emit    = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // a table edit is broadcast to the whole row
    always_comb begin
        w_ctl.new_ent = r_new;
        w_ctl.split   = r_split;
        if ((r_state == S_DELETE) && w_stat.any_inside) begin
            w_ctl.cmd = CMD_DELETE;
        end else if (r_state == S_INSERT) begin
            w_ctl.cmd = CMD_INSERT;
        end else begin
            w_ctl.cmd = CMD_HOLD;
        end
    end

    rat_chain #(
        .ENTRIES (TABLE_ENTRIES),
        .CNT_W   (CNT_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_count  (r_count),
        .i_rd_idx (r_idx),
        .o_stat   (w_stat),
        .o_rd_ent (w_rd_ent)
    );

    // Enclosed new range splits one entry (+2); otherwise +1 unless some
    // old entry is swallowed, which frees at least one slot.
    always_comb begin
        if (w_stat.any_encl) begin
            w_overflow = ((CNT_W + 2)'(r_count) + (CNT_W + 2)'(2))
                         > (CNT_W + 2)'(TABLE_ENTRIES);
        end else begin
            w_overflow = !w_stat.any_inside &&
                         (((CNT_W + 2)'(r_count) + (CNT_W + 2)'(1))
                          > (CNT_W + 2)'(TABLE_ENTRIES));
        end
    end

    assign w_rd_hit = CMP_W'(r_idx) < CMP_W'(r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_split   = r_split;
        n_status  = r_status;
        n_res_vld = r_res_vld;
        n_res_ent = r_res_ent;
        n_m_valid = r_m_valid;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = S_ANALYZE;
                    n_split   = 1'b0;
                    n_res_vld = 1'b0;
                    n_res_ent = '0;
                end
            end
            S_ANALYZE: begin
                if (r_op == OP_READ) begin
                    n_status  = ST_READ;
                    n_res_vld = w_rd_hit;
                    n_res_ent = w_rd_hit ? w_rd_ent : '0;
                    n_state   = S_FINISH;
                end else if (r_new.start_addr > r_new.end_addr) begin
                    n_status = ST_REJECTED;
                    n_state  = S_FINISH;
                end else if (w_stat.any_match) begin
                    // the matching entry is the only one inside the range
                    n_status = ST_REMOVED;
                    n_state  = S_DELETE;
                end else if (w_overflow) begin
                    n_status = ST_REJECTED;
                    n_state  = S_FINISH;
                end else begin
                    n_status = ST_INSERTED;
                    n_split  = w_stat.any_encl;
                    n_state  = w_stat.any_inside ? S_DELETE : S_INSERT;
                end
            end
            S_DELETE: begin
                if (w_stat.any_inside) begin
                    n_count = r_count - CNT_W'(1);
                end else if (r_status == ST_REMOVED) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                n_count = r_count + CNT_W'(1) + CNT_W'(r_split);
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_can_emit) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_split   <= n_split;
        r_status  <= n_status;
        r_res_vld <= n_res_vld;
        r_res_ent <= n_res_ent;
        if (w_accept) begin
            r_op             <= s_axis_tuser;
            r_new.kind       <= s_axis_tdata[1:0];
            r_new.start_addr <= s_axis_tdata[17:2];
            r_new.end_addr   <= s_axis_tdata[33:18];
            r_idx            <= s_axis_tdata[37:34];
        end
        if ((r_state == S_FINISH) && w_can_emit) begin
            r_m_user <= r_status;
            r_m_data <= {r_res_ent.end_addr, r_res_ent.start_addr, r_res_ent.kind,
                         r_res_vld, COUNT_OUT_W'(r_count)};
        end
    end

    // table never grows past its slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W + 1)'(r_count) <= (CNT_W + 1)'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // an insert adds one entry, or two when an old entry was split
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |=>
        (r_count == $past(r_count) + CNT_W'(1) + CNT_W'($past(r_split))))
        else $error("insert count update wrong");

    // a left shift of the row always drops exactly one entry
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.cmd == CMD_DELETE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete count update wrong");

    // sorted, disjoint table: an enclosing entry leaves nothing inside
    a_encl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANALYZE) && (r_op == OP_ASSIGN) && w_stat.any_encl
        |-> !w_stat.any_inside)
        else $error("enclosing and enclosed entries at once");

    // a finished result waits while the output register is still full
    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && !w_can_emit |=> (r_state == S_FINISH) && r_m_valid)
        else $error("result dropped under stall");

endmodule

`default_nettype wire
